/* rtl/core/csir_pkg.sv */
// Shared types, codes and constants for the circular sequence unit.
// No dependencies; every other file of the block imports this package.
package csir_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 2;
    localparam int POS_W = 5;
    localparam int STAT_W = 2;
    localparam int COUNT_OUT_W = 5;

    // Width of index and count compares; covers the largest supported capacity.
    localparam int CMD_W = 9;
    localparam int CAPACITY_MAX = 256;
    localparam int CAPACITY_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

    typedef logic [DATA_W-1:0] t_data;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             adv;
        logic [CMD_W-1:0] at;
        logic [CMD_W-1:0] cnt;
    } t_cell_cmd;

endpackage

/* rtl/core/csir_cell.sv */
// One storage cell of the chain: holds one element and loads from its
// neighbors, the request value or the front element. Depends on csir_pkg.
module csir_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  csir_pkg::t_cell_cmd i_cmd,
    input  csir_pkg::t_data    i_left,
    input  csir_pkg::t_data    i_right,
    input  csir_pkg::t_data    i_front,
    input  csir_pkg::t_data    i_value,
    output csir_pkg::t_data    o_data
);
    import csir_pkg::*;

    localparam logic [CMD_W-1:0] K_IDX = CMD_W'(IDX);
    localparam logic [CMD_W-1:0] K_NEXT = CMD_W'(IDX + 1);

    t_data r_data;
    t_data n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (K_IDX == i_cmd.at) begin
                n_data = i_value;
            end else if (K_IDX > i_cmd.at && K_IDX <= i_cmd.cnt) begin
                n_data = i_left;
            end
        end else if (i_cmd.rem) begin
            if (K_IDX >= i_cmd.at && K_NEXT < i_cmd.cnt) begin
                n_data = i_right;
            end
        end else if (i_cmd.adv) begin
            if (K_NEXT < i_cmd.cnt) begin
                n_data = i_right;
            end else if (K_NEXT == i_cmd.cnt) begin
                n_data = i_front;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* rtl/core/circular_sequence_insert_remove_rotate_unit.sv */
// Top level of the circular sequence unit: request decode, the chain of
// cells and the result registers. Depends on csir_pkg and csir_cell.
//
// Usage
// The block keeps an ordered sequence of up to CAPACITY signed 32-bit
// elements, front at cell 0. A request is accepted at a rising edge where
// start is high and busy is low; it inserts i_value at a position (or at
// the end), removes the element at a position (or the last one), or
// advances the sequence so the front element moves to the back.
// Every cell decides locally, from the broadcast command and its own index,
// whether to hold, take its left or right neighbor, load the new value or
// load the front element, so a whole request finishes in the accepting edge.
// The result is on the o_ ports, with o_valid high, for exactly one cycle:
// the cycle after the accepting edge. Throughput: one item per cycle;
// busy stays low, since the chain updates completely at every edge.
// The result carries the status, the removed element, the front and back
// elements and the count after the request. The receiver cannot stall; a
// result not taken in its cycle is lost.
// Reset (synchronous, active low) empties the sequence and clears o_valid.
// Cell contents are not reset; only cells below the count are ever read.
module circular_sequence_insert_remove_rotate_unit #(
    parameter int CAPACITY = csir_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [csir_pkg::MODE_W-1:0]         i_mode,
    input  logic                                i_at_end,
    input  logic [csir_pkg::POS_W-1:0]          i_position,
    input  logic signed [csir_pkg::DATA_W-1:0]  i_value,
    output logic                                o_valid,
    output logic [csir_pkg::STAT_W-1:0]         o_status,
    output logic signed [csir_pkg::DATA_W-1:0]  o_removed_value,
    output logic signed [csir_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [csir_pkg::DATA_W-1:0]  o_back_value,
    output logic [csir_pkg::COUNT_OUT_W-1:0]    o_count
);
    import csir_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CMD_W-1:0] CAP_V = CMD_W'(CAPACITY);

    logic                accept;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CMD_W-1:0]    cnt_ext;
    logic [CMD_W-1:0]    pos_ext;
    logic [CMD_W-1:0]    at_ins;
    logic [CMD_W-1:0]    at_rem;
    logic [STAT_W-1:0]   req_status;
    logic                ins_ok;
    logic                rem_ok;
    logic                adv_ok;
    t_cell_cmd           cell_cmd;
    t_data               cell_data [CAPACITY];
    t_data               sel_removed;
    t_data               sel_back;
    logic                r_valid;
    logic [STAT_W-1:0]   r_status;
    t_data               r_removed;

    // The block finishes every request at its accepting edge.
    assign busy = 1'b0;
    assign accept = start && !busy;

    assign cnt_ext = CMD_W'(r_count);
    assign pos_ext = CMD_W'(i_position);
    assign at_ins = i_at_end ? cnt_ext : pos_ext;
    assign at_rem = i_at_end ? (cnt_ext - 1'b1) : pos_ext;

    // Request decode. The position check of an insert comes before the
    // full check; remove and advance on an empty sequence report empty.
    always_comb begin
        req_status = ST_OK;
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        adv_ok = 1'b0;
        unique case (i_mode)
            MODE_INSERT: begin
                if (at_ins > cnt_ext) begin
                    req_status = ST_BADPOS;
                end else if (cnt_ext >= CAP_V) begin
                    req_status = ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (cnt_ext == '0) begin
                    req_status = ST_EMPTY;
                end else if (at_rem >= cnt_ext) begin
                    req_status = ST_BADPOS;
                end else begin
                    rem_ok = 1'b1;
                end
            end
            MODE_ADVANCE: begin
                if (cnt_ext == '0) begin
                    req_status = ST_EMPTY;
                end else begin
                    adv_ok = 1'b1;
                end
            end
            default: begin
                req_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        cell_cmd.ins = accept && ins_ok;
        cell_cmd.rem = accept && rem_ok;
        cell_cmd.adv = accept && adv_ok;
        cell_cmd.at = i_mode == MODE_INSERT ? at_ins : at_rem;
        cell_cmd.cnt = cnt_ext;
    end

    always_comb begin
        n_count = r_count;
        if (cell_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (cell_cmd.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    // The chain: each cell sees its neighbors; the ends see themselves.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        csir_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cell_cmd),
            .i_left (cell_data[(k == 0) ? 0 : k - 1]),
            .i_right(cell_data[(k == CAPACITY - 1) ? k : k + 1]),
            .i_front(cell_data[0]),
            .i_value(t_data'(i_value)),
            .o_data (cell_data[k])
        );
    end

    // One-hot pick of the removed element (old contents) and of the back
    // element (new contents, during the result cycle).
    always_comb begin
        sel_removed = '0;
        sel_back = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CMD_W'(k) == at_rem) begin
                sel_removed = sel_removed | cell_data[k];
            end
            if (CMD_W'(k + 1) == cnt_ext) begin
                sel_back = sel_back | cell_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= req_status;
            r_removed <= rem_ok ? sel_removed : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_removed_value = r_removed;
    assign o_front_value = (cnt_ext != '0) ? cell_data[0] : '0;
    assign o_back_value = sel_back;
    assign o_count = cnt_ext[COUNT_OUT_W-1:0];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext <= CAP_V)
        else $error("element count above capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted item without a result in the next cycle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> cnt_ext == CAP_V)
        else $error("full status while the store is not full");

    a_empty_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cnt_ext == '0) |-> (o_front_value == '0 && o_back_value == '0))
        else $error("empty sequence reports a nonzero front or back");

    a_removed_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_removed_value == '0)
        else $error("removed value reported on a failed request");
`endif

endmodule

/* tb/circular_sequence_insert_remove_rotate_unit_tb.sv */
// Self-checking testbench for circular_sequence_insert_remove_rotate_unit.
// Depends on csir_pkg and the unit's RTL. It drives directed and random
// requests, predicts each result and compares it field by field.
`timescale 1ns / 1ps

module circular_sequence_insert_remove_rotate_unit_tb;

    import csir_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    // The mode field has a fourth encoding that the block must treat as a no-op.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    typedef struct {
        logic [STAT_W-1:0]      status;
        t_data                  removed;
        t_data                  front;
        t_data                  back;
        logic [COUNT_OUT_W-1:0] count;
    } t_seq_result;

    // Scoreboard: holds a shadow copy of the sequence, predicts the result of
    // every accepted request and checks the results in order of arrival.
    class seq_tracker;
        t_data       elems [CAP];
        int unsigned n_elems;
        t_seq_result pending_results[$];
        int unsigned errors;
        int unsigned n_requests;
        int unsigned n_checked;
        int unsigned n_peak;
        int unsigned mode_hits [4];
        int unsigned status_hits [4];

        function new();
            foreach (elems[i]) elems[i] = '0;
            n_elems = 0;
            errors = 0;
            n_requests = 0;
            n_checked = 0;
            n_peak = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function int unsigned size();
            return n_elems;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Applies one accepted request to the shadow sequence and queues the
        // result the block must report for it.
        function void predict_request(logic [MODE_W-1:0] mode, logic at_end,
                                      logic [POS_W-1:0] pos, t_data value);
            t_seq_result r;
            int unsigned at;
            t_data       first;
            r.status = ST_OK;
            r.removed = '0;
            r.front = '0;
            r.back = '0;
            case (mode)
                MODE_INSERT: begin
                    at = at_end ? n_elems : int'(pos);
                    if (at > n_elems) begin
                        r.status = ST_BADPOS;
                    end else if (n_elems >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = n_elems; i > at; i--) elems[i] = elems[i-1];
                        elems[at] = value;
                        n_elems++;
                    end
                end
                MODE_REMOVE: begin
                    if (n_elems == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        at = at_end ? n_elems - 1 : int'(pos);
                        if (at >= n_elems) begin
                            r.status = ST_BADPOS;
                        end else begin
                            r.removed = elems[at];
                            for (int i = at; i + 1 < n_elems; i++) elems[i] = elems[i+1];
                            n_elems--;
                        end
                    end
                end
                MODE_ADVANCE: begin
                    if (n_elems == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        first = elems[0];
                        for (int i = 0; i + 1 < n_elems; i++) elems[i] = elems[i+1];
                        elems[n_elems-1] = first;
                    end
                end
                default: begin
                end
            endcase
            if (n_elems != 0) begin
                r.front = elems[0];
                r.back = elems[n_elems-1];
            end
            r.count = n_elems[COUNT_OUT_W-1:0];
            pending_results.push_back(r);
            n_requests++;
            mode_hits[mode]++;
            status_hits[r.status]++;
            if (n_elems > n_peak) n_peak = n_elems;
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                    logic [DATA_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [STAT_W-1:0] status, t_data removed,
                                   t_data front, t_data back,
                                   logic [COUNT_OUT_W-1:0] count);
            t_seq_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding, status %h count %h",
                         $time, status, count);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            n_checked++;
            compare_field("status", DATA_W'(e.status), DATA_W'(status));
            compare_field("removed_value", e.removed, removed);
            compare_field("front_value", e.front, front);
            compare_field("back_value", e.back, back);
            compare_field("count", DATA_W'(e.count), DATA_W'(count));
        endfunction

        function void check_drained();
            if (pending_results.size() != 0) begin
                $display("%0t: %0d results never arrived", $time, pending_results.size());
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [MODE_W-1:0]      i_mode = MODE_INSERT;
    logic                   i_at_end = 1'b0;
    logic [POS_W-1:0]       i_position = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                   o_valid;
    logic [STAT_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_removed_value;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_back_value;
    logic [COUNT_OUT_W-1:0] o_count;

    seq_tracker seq_sb = new();

    circular_sequence_insert_remove_rotate_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_at_end       (i_at_end),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_removed_value(o_removed_value),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_count        (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results are strobed for one cycle and cannot be held off, so every
    // rising edge with o_valid high is checked. Values are read before the
    // block's own updates at that edge take effect.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seq_sb.check_result(o_status, o_removed_value, o_front_value,
                                o_back_value, o_count);
        end
    end

    // Presents one request and holds it until the block takes it. Each cycle
    // before the request is an idle cycle with the given chance in a hundred.
    // The prediction is made here, at the accepting edge, so the next random
    // choice always sees the updated occupancy.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic at_end,
                             input logic [POS_W-1:0] pos, input t_data value,
                             input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_at_end <= at_end;
        i_position <= pos;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        seq_sb.predict_request(mode, at_end, pos, value);
    endtask

    // Values lean toward the extremes and the all-ones and all-zeros words.
    function automatic t_data pick_value();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly positions that land inside the sequence; some past the
    // end and some anywhere in the field, to exercise the bad position path.
    function automatic logic [POS_W-1:0] pick_position(int unsigned limit);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 78) return POS_W'($urandom_range(0, limit));
        if (sel < 90 && limit < 31) return POS_W'($urandom_range(limit + 1, 31));
        return POS_W'($urandom_range(0, 31));
    endfunction

    // One random request. Occupancy drifts between filling and draining
    // stretches so that both the full and the empty corners get visited.
    task automatic send_random(input bit fill_bias, input int idle_pct);
        int                sel;
        int unsigned       n;
        logic [MODE_W-1:0] mode;
        logic              at_end;
        logic [POS_W-1:0]  pos;
        sel = $urandom_range(0, 99);
        n = seq_sb.size();
        if (sel < (fill_bias ? 60 : 20)) mode = MODE_INSERT;
        else if (sel < 80) mode = MODE_REMOVE;
        else if (sel < 95) mode = MODE_ADVANCE;
        else mode = MODE_NONE;
        at_end = ($urandom_range(0, 99) < 30);
        case (mode)
            MODE_INSERT: pos = pick_position(n);
            MODE_REMOVE: pos = (n == 0) ? POS_W'($urandom_range(0, 31))
                                        : pick_position(n - 1);
            default:     pos = POS_W'($urandom_range(0, 31));
        endcase
        send_item(mode, at_end, pos, pick_value(), idle_pct);
    endtask

    initial begin
        int waited;
        int sender_idle [3];
        sender_idle[0] = 23;
        sender_idle[1] = 50;
        sender_idle[2] = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-store errors, bad insert positions, inserts of
        // the extreme values at the front, at the end and at the append
        // position, a bad remove position, the unused selector, rotation and
        // removals from the end and the middle.
        send_item(MODE_REMOVE, 1'b0, 5'd0, 32'd0, 0);
        send_item(MODE_ADVANCE, 1'b0, 5'd0, 32'd0, 0);
        send_item(MODE_INSERT, 1'b0, 5'd1, 32'd5, 0);
        send_item(MODE_INSERT, 1'b0, 5'd0, 32'h7FFF_FFFF, 0);
        send_item(MODE_INSERT, 1'b1, 5'd31, 32'h8000_0000, 0);
        send_item(MODE_INSERT, 1'b0, 5'd2, 32'hFFFF_FFFF, 0);
        send_item(MODE_INSERT, 1'b0, 5'd1, 32'h0000_0000, 0);
        send_item(MODE_INSERT, 1'b0, 5'd31, 32'h1234_5678, 0);
        send_item(MODE_REMOVE, 1'b0, 5'd4, 32'd0, 0);
        send_item(MODE_NONE, 1'b1, 5'd31, 32'hFFFF_FFFF, 0);
        send_item(MODE_ADVANCE, 1'b0, 5'd0, 32'd0, 0);
        send_item(MODE_REMOVE, 1'b1, 5'd17, 32'd0, 0);
        send_item(MODE_REMOVE, 1'b0, 5'd1, 32'd0, 0);

        // Fill to capacity, then hit the full store: the bad position check
        // has priority over the full check.
        while (seq_sb.size() < CAP) send_item(MODE_INSERT, 1'b1, 5'd0, pick_value(), 0);
        send_item(MODE_INSERT, 1'b1, 5'd0, 32'h0BAD_0BAD, 0);
        send_item(MODE_INSERT, 1'b0, 5'd17, 32'h0BAD_0BAD, 0);
        send_item(MODE_INSERT, 1'b0, 5'd16, 32'h0BAD_0BAD, 0);
        send_item(MODE_ADVANCE, 1'b0, 5'd0, 32'd0, 0);
        send_item(MODE_REMOVE, 1'b0, 5'd15, 32'd0, 0);

        // Random part in three pacing phases: light sender gaps, heavy sender
        // gaps, then back-to-back requests.
        for (int phase = 0; phase < 3; phase++) begin
            for (int k = 0; k < 270; k++) begin
                send_random(((k / 40) % 2) == 0, sender_idle[phase]);
            end
        end
        start <= 1'b0;

        // The result comes in the cycle after its request; allow a little slack.
        waited = 0;
        while (seq_sb.outstanding() != 0 && waited < 50) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        seq_sb.check_drained();

        $display("Covered %0d requests (insert %0d, remove %0d, advance %0d, unused %0d);",
                 seq_sb.n_requests, seq_sb.mode_hits[0], seq_sb.mode_hits[1],
                 seq_sb.mode_hits[2], seq_sb.mode_hits[3]);
        $display("%0d results checked; statuses ok/bad position/empty/full: %0d/%0d/%0d/%0d;",
                 seq_sb.n_checked, seq_sb.status_hits[0], seq_sb.status_hits[1],
                 seq_sb.status_hits[2], seq_sb.status_hits[3]);
        $display("peak occupancy %0d of %0d.", seq_sb.n_peak, CAP);
        if (seq_sb.errors == 0) begin
            $display("circular_sequence_insert_remove_rotate_unit regression: pass");
        end else begin
            $display("circular_sequence_insert_remove_rotate_unit regression: fail");
        end
        $finish;
    end

    // Watchdog: the run needs well under a hundred microseconds.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", seq_sb.outstanding());
        $display("circular_sequence_insert_remove_rotate_unit regression: fail");
        $finish;
    end

endmodule
